// File: src/bdrt_pkg.sv
package bdrt_pkg;

  localparam int unsigned OFS_W   = 20;
  localparam int unsigned REG_W   = 11;
  localparam int unsigned FSIZE_W = 22;
  localparam int unsigned BANK_W  = 4;
  localparam int unsigned START_W = 16;
  localparam int unsigned COUNT_W = 17;
  localparam int unsigned ADDR_W  = 4;
  localparam int unsigned DATA_W  = 32;
  localparam int unsigned Q_DEPTH = 2;

  localparam logic [OFS_W-1:0] OFS_MAX = '1;

  localparam logic [1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [1:0] REG_FRAME_HEIGHT = 2'd1;
  localparam logic [1:0] REG_ROW_PITCH    = 2'd2;

  localparam logic [REG_W-1:0]   FRAME_WIDTH_RST  = 11'd640;
  localparam logic [REG_W-1:0]   FRAME_HEIGHT_RST = 11'd480;
  localparam logic [REG_W-1:0]   ROW_PITCH_RST    = 11'd640;
  localparam logic [FSIZE_W-1:0] FRAME_SIZE_RST   = 22'd307200;

  typedef struct packed {
    logic             is_sync;
    logic [OFS_W-1:0] first_ofs;
    logic [OFS_W-1:0] last_ofs;
  } work_t;

  typedef struct packed {
    logic full;
    logic not_empty;
  } q_stat_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_WALK = 2'b10
  } back_state_e;

endpackage

// File: src/bdrt_front.sv
module bdrt_front
  import bdrt_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic             req_type_i,
  input  logic [9:0]       rect_x_i,
  input  logic [9:0]       rect_y_i,
  input  logic [10:0]      rect_w_i,
  input  logic [10:0]      rect_h_i,
  input  logic [REG_W-1:0] frame_width_i,
  input  logic [REG_W-1:0] frame_height_i,
  input  logic [REG_W-1:0] row_pitch_i,
  input  q_stat_t          q_stat_i,
  output logic             push_o,
  output work_t            word_o
);

  logic             drop;
  logic [11:0]      x_end;
  logic [11:0]      y_end;
  logic [REG_W-1:0] last_col;
  logic [REG_W-1:0] last_row;
  logic             en1;
  logic             en2;

  logic             v1_q;
  logic             sync1_q;
  logic [9:0]       x1_q;
  logic [9:0]       y1_q;
  logic [REG_W-1:0] lc1_q;
  logic [REG_W-1:0] lr1_q;

  logic             v2_q;
  logic             sync2_q;
  logic [20:0]      pf2_q;
  logic [21:0]      pl2_q;
  logic [9:0]       x2_q;
  logic [REG_W-1:0] lc2_q;

  logic [21:0]      sum_first;
  logic [22:0]      sum_last;

  always_comb begin
    x_end    = 12'(rect_x_i) + 12'(rect_w_i);
    y_end    = 12'(rect_y_i) + 12'(rect_h_i);
    last_col = (x_end > 12'(frame_width_i)) ? frame_width_i - 11'd1
                                            : 11'(x_end - 12'd1);
    last_row = (y_end > 12'(frame_height_i)) ? frame_height_i - 11'd1
                                             : 11'(y_end - 12'd1);
    drop     = !req_type_i && (rect_w_i == 11'd0 || rect_h_i == 11'd0 ||
               row_pitch_i == 11'd0 || 11'(rect_x_i) >= frame_width_i ||
               11'(rect_y_i) >= frame_height_i);
  end

  assign en2        = !v2_q || !q_stat_i.full;
  assign en1        = !v1_q || en2;
  assign in_stall_o = !en1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (en1) begin
        v1_q <= in_valid_i && !drop;
      end
      if (en2) begin
        v2_q <= v1_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1 && in_valid_i) begin
      sync1_q <= req_type_i;
      x1_q    <= rect_x_i;
      y1_q    <= rect_y_i;
      lc1_q   <= last_col;
      lr1_q   <= last_row;
    end
    if (en2 && v1_q) begin
      sync2_q <= sync1_q;
      pf2_q   <= 21'(y1_q) * 21'(row_pitch_i);
      pl2_q   <= 22'(lr1_q) * 22'(row_pitch_i);
      x2_q    <= x1_q;
      lc2_q   <= lc1_q;
    end
  end

  always_comb begin
    sum_first        = 22'(pf2_q) + 22'(x2_q);
    sum_last         = 23'(pl2_q) + 23'(lc2_q);
    word_o.is_sync   = sync2_q;
    word_o.first_ofs = (sum_first > 22'(OFS_MAX)) ? OFS_MAX : sum_first[OFS_W-1:0];
    word_o.last_ofs  = (sum_last > 23'(OFS_MAX)) ? OFS_MAX : sum_last[OFS_W-1:0];
  end

  assign push_o = v2_q && !q_stat_i.full;

endmodule

// File: src/bdrt_fifo.sv
module bdrt_fifo
  import bdrt_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  work_t   word_i,
  input  logic    pop_i,
  output work_t   word_o,
  output q_stat_t q_stat_o
);

  localparam int unsigned PTR_W = $clog2(Q_DEPTH);
  localparam int unsigned CNT_W = $clog2(Q_DEPTH + 1);

  work_t            mem_q [Q_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q;
  logic [PTR_W-1:0] rd_ptr_q;
  logic [CNT_W-1:0] count_q;

  assign q_stat_o.full      = (count_q == CNT_W'(Q_DEPTH));
  assign q_stat_o.not_empty = (count_q != '0);
  assign word_o             = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= word_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i && !pop_i |-> !q_stat_o.full)
    else $error("Queue written while full.");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> q_stat_o.not_empty)
    else $error("Queue read while empty.");

endmodule

// File: src/bdrt_back.sv
module bdrt_back
  import bdrt_pkg::*;
#(
  parameter int unsigned BANK_BYTES = 65536,
  parameter int unsigned MAX_BANKS  = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  work_t              word_i,
  input  q_stat_t            q_stat_i,
  output logic               pop_o,
  input  logic [FSIZE_W-1:0] frame_size_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [BANK_W-1:0]  seg_bank_o,
  output logic [START_W-1:0] seg_start_o,
  output logic [COUNT_W-1:0] seg_count_o,
  output logic               seg_last_o
);

  localparam int unsigned BANK_LOG2 = $clog2(BANK_BYTES);
  localparam int unsigned HI_W      = OFS_W - BANK_LOG2;
  localparam logic [OFS_W-1:0] LOW_MASK = OFS_W'(BANK_BYTES - 1);

  back_state_e       state_q;
  logic              pending_q;
  logic [OFS_W-1:0]  first_q;
  logic [OFS_W-1:0]  last_q;
  logic [BANK_W-1:0] bank_q;
  logic              lead_q;

  logic               out_v_q;
  logic [BANK_W-1:0]  seg_bank_q;
  logic [START_W-1:0] seg_start_q;
  logic [COUNT_W-1:0] seg_count_q;
  logic               seg_last_q;

  logic               out_free;
  logic               pop_mark;
  logic               pop_sync;
  logic               emit_empty;
  logic               emit_walk;
  logic               range_ok;
  logic [HI_W-1:0]    bank_lo;
  logic [HI_W-1:0]    bank_hi;
  logic [OFS_W-1:0]   first_base;
  logic               is_last_bank;
  logic [BANK_W:0]    next_bank;
  logic [FSIZE_W-1:0] next_base;
  logic               walk_last;
  logic [START_W-1:0] walk_start;
  logic [COUNT_W-1:0] walk_end;

  always_comb begin
    out_free     = !out_v_q || !out_stall_i;
    bank_lo      = first_q[OFS_W-1:BANK_LOG2];
    bank_hi      = last_q[OFS_W-1:BANK_LOG2];
    first_base   = first_q & ~LOW_MASK;
    range_ok     = pending_q && ({1'b0, bank_lo} < (HI_W + 1)'(MAX_BANKS)) &&
                   (FSIZE_W'(first_base) < frame_size_i);
    pop_mark     = (state_q == ST_IDLE) && q_stat_i.not_empty && !word_i.is_sync;
    pop_sync     = (state_q == ST_IDLE) && q_stat_i.not_empty && word_i.is_sync &&
                   out_free;
    pop_o        = pop_mark || pop_sync;
    emit_empty   = pop_sync && !range_ok;
    emit_walk    = (state_q == ST_WALK) && out_free;
    is_last_bank = ((HI_W + 1)'(bank_q) == {1'b0, bank_hi});
    next_bank    = (BANK_W + 1)'(bank_q) + 1'b1;
    next_base    = FSIZE_W'(next_bank) << BANK_LOG2;
    walk_last    = is_last_bank || (next_bank >= (BANK_W + 1)'(MAX_BANKS)) ||
                   (next_base >= frame_size_i);
    walk_start   = lead_q ? START_W'(first_q & LOW_MASK) : '0;
    walk_end     = is_last_bank ? COUNT_W'(last_q & LOW_MASK) + 1'b1
                                : COUNT_W'(BANK_BYTES);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      pending_q <= 1'b0;
      first_q   <= '0;
      last_q    <= '0;
      bank_q    <= '0;
      lead_q    <= 1'b0;
      out_v_q   <= 1'b0;
    end else begin
      if (out_free) begin
        out_v_q <= emit_empty || emit_walk;
      end
      if (pop_mark) begin
        pending_q <= 1'b1;
        if (!pending_q || word_i.first_ofs < first_q) begin
          first_q <= word_i.first_ofs;
        end
        if (!pending_q || word_i.last_ofs > last_q) begin
          last_q <= word_i.last_ofs;
        end
      end
      if (pop_sync) begin
        pending_q <= 1'b0;
        if (range_ok) begin
          state_q <= ST_WALK;
          bank_q  <= bank_lo[BANK_W-1:0];
          lead_q  <= 1'b1;
        end
      end
      if (emit_walk) begin
        lead_q <= 1'b0;
        if (walk_last) begin
          state_q <= ST_IDLE;
        end else begin
          bank_q <= bank_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_empty) begin
      seg_bank_q  <= '0;
      seg_start_q <= '0;
      seg_count_q <= '0;
      seg_last_q  <= 1'b1;
    end else if (emit_walk) begin
      seg_bank_q  <= bank_q;
      seg_start_q <= walk_start;
      seg_count_q <= walk_end - COUNT_W'(walk_start);
      seg_last_q  <= walk_last;
    end
  end

  assign out_valid_o = out_v_q;
  assign seg_bank_o  = seg_bank_q;
  assign seg_start_o = seg_start_q;
  assign seg_count_o = seg_count_q;
  assign seg_last_o  = seg_last_q;

  a_bank_in_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_WALK |-> (BANK_W + 1)'(bank_q) < (BANK_W + 1)'(MAX_BANKS))
    else $error("Bank walk beyond the bank limit.");

  a_empty_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q && seg_count_q == '0 |-> seg_last_q)
    else $error("Empty segment not marked last.");

  a_sync_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_sync |=> !pending_q)
    else $error("Pending range survived a sync.");

  a_no_pop_in_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_WALK |-> !pop_o)
    else $error("Queue read during a bank walk.");

endmodule

// File: src/banked_dirty_range_tracker.sv
// Dirty range tracker for a linear 8-bit shadow framebuffer. A mark word clips its rectangle
// to the frame and is turned into first and last byte offsets by a front pipeline of two
// register stages (the second holds the two row-pitch products) before it enters a two-entry
// queue; the back end merges one queued mark per cycle into the pending range while it is
// idle. A sync word that covers banks leaves the queue and then emits 1 to MAX_BANKS
// segments, held while the output is stalled; a sync with nothing to copy registers its
// single empty segment as it leaves the queue. No queued word is taken while segments are
// being emitted. The frame size used to cut off banks is registered from the row pitch and
// frame height registers, so a configuration write reaches it after those registers.
module banked_dirty_range_tracker
  import bdrt_pkg::*;
#(
  parameter int unsigned BANK_BYTES = 65536,
  parameter int unsigned MAX_BANKS  = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               req_type_i,
  input  logic [9:0]         rect_x_i,
  input  logic [9:0]         rect_y_i,
  input  logic [10:0]        rect_w_i,
  input  logic [10:0]        rect_h_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [BANK_W-1:0]  seg_bank_o,
  output logic [START_W-1:0] seg_start_o,
  output logic [COUNT_W-1:0] seg_count_o,
  output logic               seg_last_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [ADDR_W-1:0]  paddr,
  input  logic [DATA_W-1:0]  pwdata,
  output logic [DATA_W-1:0]  prdata,
  output logic               pready
);

  logic [REG_W-1:0]   frame_width_q;
  logic [REG_W-1:0]   frame_height_q;
  logic [REG_W-1:0]   row_pitch_q;
  logic [FSIZE_W-1:0] frame_size_q;
  logic               cfg_we;
  logic [1:0]         cfg_idx;

  logic    push;
  logic    pop;
  work_t   push_word;
  work_t   head_word;
  q_stat_t q_stat;

  assign pready  = 1'b1;
  assign cfg_idx = paddr[3:2];
  assign cfg_we  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= FRAME_WIDTH_RST;
      frame_height_q <= FRAME_HEIGHT_RST;
      row_pitch_q    <= ROW_PITCH_RST;
      frame_size_q   <= FRAME_SIZE_RST;
    end else begin
      frame_size_q <= 22'(row_pitch_q) * 22'(frame_height_q);
      if (cfg_we) begin
        case (cfg_idx)
          REG_FRAME_WIDTH: begin
            frame_width_q <= pwdata[REG_W-1:0];
          end
          REG_FRAME_HEIGHT: begin
            frame_height_q <= pwdata[REG_W-1:0];
          end
          REG_ROW_PITCH: begin
            row_pitch_q <= pwdata[REG_W-1:0];
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_FRAME_WIDTH:  prdata = DATA_W'(frame_width_q);
      REG_FRAME_HEIGHT: prdata = DATA_W'(frame_height_q);
      REG_ROW_PITCH:    prdata = DATA_W'(row_pitch_q);
      default:          prdata = '0;
    endcase
  end

  bdrt_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .req_type_i     (req_type_i),
    .rect_x_i       (rect_x_i),
    .rect_y_i       (rect_y_i),
    .rect_w_i       (rect_w_i),
    .rect_h_i       (rect_h_i),
    .frame_width_i  (frame_width_q),
    .frame_height_i (frame_height_q),
    .row_pitch_i    (row_pitch_q),
    .q_stat_i       (q_stat),
    .push_o         (push),
    .word_o         (push_word)
  );

  bdrt_fifo u_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .word_i   (push_word),
    .pop_i    (pop),
    .word_o   (head_word),
    .q_stat_o (q_stat)
  );

  bdrt_back #(
    .BANK_BYTES (BANK_BYTES),
    .MAX_BANKS  (MAX_BANKS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .word_i       (head_word),
    .q_stat_i     (q_stat),
    .pop_o        (pop),
    .frame_size_i (frame_size_q),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .seg_bank_o   (seg_bank_o),
    .seg_start_o  (seg_start_o),
    .seg_count_o  (seg_count_o),
    .seg_last_o   (seg_last_o)
  );

endmodule
